// ----- rtl/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator.
// No dependencies; imported by bpa_word_unit, bitmap_page_allocator and the testbench.
`default_nettype none

package bpa_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_IDX_W = 32 - PAGE_SHIFT;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned WORD_BITS  = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;

  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_FREE_PAGE  = 2'd1,
    REQ_RESERVE    = 2'd2,
    REQ_FREE_RANGE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGE  = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  // Controls for one read-modify-write of a bitmap word in a range update.
  typedef struct packed {
    logic     set;
    bit_idx_t lo;
    bit_idx_t hi;
  } range_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
// Bitmap page frame allocator: top level with the request sequencer and output register.
// Depends on bpa_pkg, bpa_ram and bpa_word_unit.
`default_nettype none

// The allocator keeps one bit per 4 KiB page in a RAM of BITMAP_WORDS 32-bit
// words. After reset it runs a clearing pass that zeroes every word, during
// which no request transaction is accepted (page_count writes are always
// taken). Requests are handled one at a time. An allocation reads words in
// order from a search hint, the lowest word that may still hold a free page,
// at one word per cycle. A single page free or a range reserve or free
// reads, modifies and writes back one word per cycle over the words the
// range spans. Requests that are rejected, or empty ranges, need no memory
// access. The result sits in an output register, so the next request may
// be taken while a result still waits.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned BITMAP_WORDS = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [16:0] cfg_page_count_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] start_addr_i,
  input  wire logic [31:0] end_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      page_addr_o,
  output logic [1:0]       status_o
);

  localparam int unsigned WORD_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned HINT_W = $clog2(BITMAP_WORDS + 1);
  localparam logic [PAGE_IDX_W:0] CAP = (PAGE_IDX_W + 1)'(BITMAP_WORDS * WORD_BITS);
  localparam logic [HINT_W-1:0] HINT_END  = HINT_W'(BITMAP_WORDS);
  localparam logic [HINT_W-1:0] CLEAR_END = HINT_W'(BITMAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RANGE,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [HINT_W-1:0]     hint_q, hint_d;
  logic [HINT_W-1:0]     ptr_q, ptr_d;
  logic                  pend_q, pend_d;
  logic [WORD_W-1:0]     pend_addr_q, pend_addr_d;
  logic                  issue_q, issue_d;
  logic [WORD_W-1:0]     wfirst_q, wfirst_d;
  logic [WORD_W-1:0]     wlast_q, wlast_d;
  bit_idx_t              lo_q, lo_d;
  bit_idx_t              hi_q, hi_d;
  logic                  set_q, set_d;
  logic [PAGE_IDX_W-1:0] res_page_q, res_page_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           page_addr_q, page_addr_d;
  status_e               status_q, status_d;
  logic [16:0]           page_count_q, page_count_d;

  logic              ram_we;
  logic [WORD_W-1:0] ram_waddr;
  word_t             ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_raddr;
  word_t             ram_rdata;

  range_ctl_t ctl;
  word_t      range_wdata;
  logic       zero_found;
  bit_idx_t   zero_bit;
  word_t      alloc_wdata;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The first and last words of a range only take the partial bit span.
  assign ctl.set = set_q;
  assign ctl.lo  = (pend_addr_q == wfirst_q) ? lo_q : '0;
  assign ctl.hi  = (pend_addr_q == wlast_q) ? hi_q : bit_idx_t'(WORD_BITS - 1);

  bpa_word_unit u_word (
    .rdata_i       (ram_rdata),
    .ctl_i         (ctl),
    .range_wdata_o (range_wdata),
    .zero_found_o  (zero_found),
    .zero_bit_o    (zero_bit),
    .alloc_wdata_o (alloc_wdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign page_addr_o = page_addr_q;
  assign status_o    = status_q;

  always_comb begin
    logic [PAGE_IDX_W-1:0] first;
    logic [PAGE_IDX_W:0]   last_ex;
    logic [PAGE_IDX_W-1:0] last_m1;
    logic [WORD_W-1:0]     wfirst_in;
    logic [PAGE_IDX_W-1:0] alloc_idx;
    logic                  out_free;

    state_d      = state_q;
    hint_d       = hint_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    issue_d      = issue_q;
    wfirst_d     = wfirst_q;
    wlast_d      = wlast_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    res_page_d   = res_page_q;
    res_status_d = res_status_q;
    page_addr_d  = page_addr_q;
    status_d     = status_q;
    page_count_d = page_count_q;

    ram_we    = 1'b0;
    ram_waddr = pend_addr_q;
    ram_wdata = range_wdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[WORD_W-1:0];

    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;

    first     = start_addr_i[31:PAGE_SHIFT];
    last_ex   = {1'b0, end_addr_i[31:PAGE_SHIFT]} +
                (PAGE_IDX_W + 1)'(|end_addr_i[PAGE_SHIFT-1:0]);
    last_m1   = PAGE_IDX_W'(last_ex - 1'b1);
    wfirst_in = first[WORD_W+BIT_W-1:BIT_W];
    alloc_idx = PAGE_IDX_W'({pend_addr_q, zero_bit});

    if (cfg_valid_i) begin
      page_count_d = cfg_page_count_i;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[WORD_W-1:0];
        ram_wdata = '0;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == CLEAR_END) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_page_d   = '0;
          res_status_d = ST_OK;
          pend_d       = 1'b0;
          case (req_e'(req_type_i))
            REQ_ALLOC: begin
              ptr_d   = hint_q;
              state_d = S_SCAN;
            end
            REQ_FREE_PAGE: begin
              if ((|start_addr_i[PAGE_SHIFT-1:0]) || ({1'b0, first} >= CAP)) begin
                res_status_d = ST_BAD_ADDR;
                state_d      = S_RESP;
              end else begin
                wfirst_d = wfirst_in;
                wlast_d  = wfirst_in;
                lo_d     = first[BIT_W-1:0];
                hi_d     = first[BIT_W-1:0];
                set_d    = 1'b0;
                ptr_d    = HINT_W'(wfirst_in);
                issue_d  = 1'b1;
                if (HINT_W'(wfirst_in) < hint_q) begin
                  hint_d = HINT_W'(wfirst_in);
                end
                state_d = S_RANGE;
              end
            end
            default: begin
              // Range reserve or free; an empty range just reports its start.
              if (last_ex <= {1'b0, first}) begin
                res_page_d = first;
                state_d    = S_RESP;
              end else if (last_ex > CAP) begin
                res_status_d = ST_BAD_ADDR;
                state_d      = S_RESP;
              end else begin
                res_page_d = first;
                wfirst_d   = wfirst_in;
                wlast_d    = last_m1[WORD_W+BIT_W-1:BIT_W];
                lo_d       = first[BIT_W-1:0];
                hi_d       = last_m1[BIT_W-1:0];
                set_d      = (req_e'(req_type_i) == REQ_RESERVE);
                ptr_d      = HINT_W'(wfirst_in);
                issue_d    = 1'b1;
                if ((req_e'(req_type_i) == REQ_FREE_RANGE) &&
                    (HINT_W'(wfirst_in) < hint_q)) begin
                  hint_d = HINT_W'(wfirst_in);
                end
                state_d = S_RANGE;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads stream one word per cycle; the word read in the previous
        // cycle is examined now.
        if (ptr_q != HINT_END) begin
          ram_re      = 1'b1;
          ptr_d       = ptr_q + 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[WORD_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (zero_found) begin
            if ({1'b0, alloc_idx} < (PAGE_IDX_W + 1)'(page_count_q)) begin
              ram_we     = 1'b1;
              ram_wdata  = alloc_wdata;
              res_page_d = alloc_idx;
            end else begin
              res_status_d = ST_NO_PAGE;
            end
            state_d = S_RESP;
          end else begin
            // Every word below the hint is known to be full.
            hint_d = HINT_W'(pend_addr_q) + 1'b1;
          end
        end else if (ptr_q == HINT_END) begin
          res_status_d = ST_NO_PAGE;
          state_d      = S_RESP;
        end
      end

      S_RANGE: begin
        // Read of the next word overlaps the write-back of the current one.
        if (issue_q) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[WORD_W-1:0];
          ptr_d       = ptr_q + 1'b1;
          if (ptr_q[WORD_W-1:0] == wlast_q) begin
            issue_d = 1'b0;
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we = 1'b1;
          if (!issue_q) begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          page_addr_d = {res_page_q, {PAGE_SHIFT{1'b0}}};
          status_d    = res_status_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      hint_q       <= '0;
      ptr_q        <= '0;
      pend_q       <= 1'b0;
      issue_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      page_count_q <= 17'h10000;
    end else begin
      state_q      <= state_d;
      hint_q       <= hint_d;
      ptr_q        <= ptr_d;
      pend_q       <= pend_d;
      issue_q      <= issue_d;
      out_valid_q  <= out_valid_d;
      page_count_q <= page_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    wfirst_q     <= wfirst_d;
    wlast_q      <= wlast_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    set_q        <= set_d;
    res_page_q   <= res_page_d;
    res_status_q <= res_status_d;
    page_addr_q  <= page_addr_d;
    status_q     <= status_d;
  end

endmodule

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bpa_word_unit.sv -----
// Word datapath of the allocator: range mask update and lowest free bit search.
// Depends on bpa_pkg.
`default_nettype none

module bpa_word_unit
  import bpa_pkg::*;
(
  input  wire word_t      rdata_i,
  input  wire range_ctl_t ctl_i,
  output word_t           range_wdata_o,
  output logic            zero_found_o,
  output bit_idx_t        zero_bit_o,
  output word_t           alloc_wdata_o
);

  word_t mask;

  // Bits lo..hi inclusive of the word are affected by the range.
  assign mask = ({WORD_BITS{1'b1}} << ctl_i.lo) &
                ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - ctl_i.hi));

  assign range_wdata_o = ctl_i.set ? (rdata_i | mask) : (rdata_i & ~mask);

  assign zero_found_o = ~&rdata_i;

  always_comb begin
    zero_bit_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata_i[i]) begin
        zero_bit_o = BIT_W'(i);
      end
    end
  end

  assign alloc_wdata_o = rdata_i | (word_t'(1) << zero_bit_o);

endmodule

`default_nettype wire

// ----- tb/sv/bitmap_page_allocator_test.sv -----
// Self-checking testbench for the bitmap page allocator: directed table, then random phases.
// Depends on bpa_pkg and bitmap_page_allocator; results are checked against an in-bench predictor.
`default_nettype none

module bitmap_page_allocator_test
  import bpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BITMAP_WORDS = 2048;
  localparam int unsigned CAPACITY     = BITMAP_WORDS * WORD_BITS;
  // The slowest correct request walks every bitmap word, and the clearing pass
  // after reset takes as long again; this bound is several times both.
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned PHASE_ITEMS  = 112;

  // One result of the block: a page address and a status code.
  typedef struct packed {
    logic [31:0] page_addr;
    status_e     status;
  } page_result_t;

  // One row of the directed table. Where known is set, the expected result is
  // written into the row; otherwise it comes from the predictor.
  typedef struct {
    req_e         req;
    logic [31:0]  start_a;
    logic [31:0]  end_a;
    bit           known;
    page_result_t want;
  } directed_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_page_count_i = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i       = REQ_ALLOC;
  logic [31:0] start_addr_i     = '0;
  logic [31:0] end_addr_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [31:0] page_addr_o;
  logic [1:0]  status_o;

  bitmap_page_allocator #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_page_count_i (cfg_page_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .start_addr_i     (start_addr_i),
    .end_addr_i       (end_addr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .page_addr_o      (page_addr_o),
    .status_o         (status_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the allocator state: the used-page bitmap (one bit per
  // page, 1 = used) and the page_count register.
  logic [WORD_BITS-1:0] used_words [BITMAP_WORDS];
  logic [16:0]          managed_pages;

  // Results predicted at request acceptance and not yet seen at the output.
  page_result_t outstanding_results [$];
  directed_row_t directed_rows [$];

  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned burst_left      = 0;
  int unsigned settings_done   = 0;
  int unsigned requests_by_type [4];
  int unsigned results_by_status [4];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Works out the result of one request and updates the shadow bitmap the way
  // the block must. Allocation takes the lowest free page overall, and only
  // if that page lies below both page_count and the bitmap capacity.
  function automatic page_result_t apply_page_request(input req_e req,
                                                      input logic [31:0] start_a,
                                                      input logic [31:0] end_a);
    page_result_t res;
    int unsigned  limit;
    int unsigned  idx;
    int unsigned  b;
    int unsigned  lo_page;
    int unsigned  hi_page;
    bit           found;
    res.page_addr = '0;
    res.status    = ST_OK;
    limit = (managed_pages < CAPACITY) ? managed_pages : CAPACITY;
    case (req)
      REQ_ALLOC: begin
        found = 1'b0;
        for (int unsigned w = 0; w < BITMAP_WORDS; w++) begin
          if (used_words[w] != '1) begin
            b = 0;
            while (used_words[w][b]) b++;
            idx = w * WORD_BITS + b;
            if (idx < limit) begin
              used_words[w][b] = 1'b1;
              res.page_addr    = idx << PAGE_SHIFT;
              found            = 1'b1;
            end
            break;
          end
        end
        if (!found) res.status = ST_NO_PAGE;
      end
      REQ_FREE_PAGE: begin
        idx = start_a >> PAGE_SHIFT;
        if (start_a[PAGE_SHIFT-1:0] != '0 || idx >= CAPACITY) begin
          res.status = ST_BAD_ADDR;
        end else begin
          used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
        end
      end
      default: begin
        // The range runs from the start page up to the end address rounded up
        // to a whole page. An empty range still reports its start page, even
        // one far beyond the bitmap.
        lo_page = start_a >> PAGE_SHIFT;
        hi_page = (end_a >> PAGE_SHIFT) + 32'(end_a[PAGE_SHIFT-1:0] != '0);
        if (hi_page <= lo_page) begin
          res.page_addr = {start_a[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        end else if (hi_page > CAPACITY) begin
          res.status = ST_BAD_ADDR;
        end else begin
          for (int unsigned p = lo_page; p < hi_page; p++) begin
            used_words[p / WORD_BITS][p % WORD_BITS] = (req == REQ_RESERVE);
          end
          res.page_addr = {start_a[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        end
      end
    endcase
    return res;
  endfunction

  task automatic add_row(input req_e req, input logic [31:0] start_a, input logic [31:0] end_a,
                         input bit known, input logic [31:0] want_addr, input status_e want_st);
    directed_row_t row;
    row.req            = req;
    row.start_a        = start_a;
    row.end_a          = end_a;
    row.known          = known;
    row.want.page_addr = want_addr;
    row.want.status    = want_st;
    directed_rows.push_back(row);
  endtask

  // Presents one request and waits for its transaction. The sender works in
  // bursts: within a burst valid stays high from one request to the next, and
  // between bursts it may drop for a random gap. The prediction is made at the
  // accepting edge, so it follows the block's own order of requests.
  task automatic send_request(input req_e req, input logic [31:0] start_a,
                              input logic [31:0] end_a, input bit known,
                              input page_result_t want);
    int unsigned  gap;
    page_result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    start_addr_i <= start_a;
    end_addr_i   <= end_a;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    requests_by_type[req]++;
    predicted = apply_page_request(req, start_a, end_a);
    outstanding_results.push_back(known ? want : predicted);
  endtask

  // Lets every outstanding result arrive, then a short pause for the block to
  // settle, so that the register write lands while the block is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (outstanding_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_page_count(input logic [16:0] value);
    drain_results();
    cfg_valid_i      <= 1'b1;
    cfg_page_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    managed_pages  = value;
    settings_done++;
  endtask

  // Random request aimed mostly at the pages below span, where allocation and
  // the range operations meet. A small share is pure noise over all bits.
  task automatic send_random_request(input int unsigned span);
    int unsigned  pick;
    int unsigned  lo_page;
    int unsigned  len;
    logic [31:0]  start_a;
    logic [31:0]  end_a;
    req_e         req;
    page_result_t none;
    none    = '0;
    pick    = $urandom_range(0, 99);
    start_a = $urandom;
    end_a   = $urandom;
    if (pick < 40) begin
      req = REQ_ALLOC;
    end else if (pick < 60) begin
      req = REQ_FREE_PAGE;
      case ($urandom_range(0, 9))
        0:       start_a[PAGE_SHIFT-1:0] = '0;
        1:       ;
        default: start_a = $urandom_range(0, span - 1) << PAGE_SHIFT;
      endcase
    end else if (pick < 95) begin
      req     = (pick < 80) ? REQ_RESERVE : REQ_FREE_RANGE;
      lo_page = $urandom_range(0, span - 1);
      if ($urandom_range(0, 49) == 0) len = $urandom_range(0, CAPACITY - lo_page);
      else len = $urandom_range(0, 40);
      start_a = lo_page << PAGE_SHIFT;
      if ($urandom_range(0, 3) == 0) start_a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
      end_a = (lo_page + len) << PAGE_SHIFT;
      if ($urandom_range(0, 3) == 0) end_a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
    end else begin
      req = req_e'($urandom_range(0, 3));
    end
    send_request(req, start_a, end_a, 1'b0, none);
  endtask

  // Receiver: out_ready_i follows a stall pattern that is drawn anew at random as the
  // test runs, from always ready through regular and random stalls.
  int unsigned stall_ctr  = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outstanding_results.size() == 0) begin
        report_mismatch($sformatf("result %h/%0d with no request outstanding",
                                  page_addr_o, status_o));
      end else begin
        want = outstanding_results.pop_front();
        if (page_addr_o !== want.page_addr)
          report_mismatch($sformatf("page_addr %h, expected %h", page_addr_o, want.page_addr));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (page_addr %h)",
                                    status_o, want.status, want.page_addr));
        results_by_status[want.status]++;
      end
    end
    stall_ctr <= stall_ctr + 1;
    if (stall_ctr % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= (stall_ctr % 4 != 0);
      2:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_ctr % 8 < 4);
    endcase
  end

  // Watchdog: a long stretch without any transaction on any channel means
  // the block has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [16:0] phase_counts [8];
    int unsigned span;
    phase_counts = '{17'd1, 17'd0, 17'd40, 17'd300, 17'd131071, 17'd65537, 17'd65536, 17'd0};
    for (int unsigned w = 0; w < BITMAP_WORDS; w++) used_words[w] = '0;
    managed_pages = 17'd65536;
    for (int unsigned i = 0; i < 4; i++) begin
      requests_by_type[i]  = 0;
      results_by_status[i] = 0;
    end

    // Directed table, run with the reset page_count. It walks the edges of
    // the address space: misaligned and out-of-range frees, empty ranges
    // (including one that starts at the top of the address space), ranges
    // ending exactly at or one byte past capacity, a full-bitmap reserve that
    // exhausts the allocator, and the very last page. It ends by freeing
    // everything so that the random phases start from an empty bitmap.
    add_row(REQ_ALLOC,      32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0000_1000, ST_OK);
    add_row(REQ_FREE_PAGE,  32'h0000_0001, 32'h0000_0000, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_FREE_PAGE,  32'h1000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_FREE_PAGE,  32'hFFFF_F000, 32'h0000_0000, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_FREE_PAGE,  32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_RESERVE,    32'h0000_5000, 32'h0000_5000, 1, 32'h0000_5000, ST_OK);
    add_row(REQ_FREE_RANGE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'hFFFF_F000, ST_OK);
    add_row(REQ_RESERVE,    32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_RESERVE,    32'h0FFF_F000, 32'h1000_0000, 1, 32'h0FFF_F000, ST_OK);
    add_row(REQ_RESERVE,    32'h0FFF_F000, 32'h1000_0001, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_RESERVE,    32'h0000_2001, 32'h0000_8001, 0, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'h0000_0000, 32'h0000_0000, 0, 32'h0000_0000, ST_OK);
    add_row(REQ_FREE_RANGE, 32'h0000_0000, 32'h1000_0000, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_RESERVE,    32'h0000_0000, 32'h1000_0000, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, ST_NO_PAGE);
    add_row(REQ_FREE_PAGE,  32'h0FFF_F000, 32'h0000_0000, 1, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'h0000_0000, 32'h0000_0000, 1, 32'h0FFF_F000, ST_OK);
    add_row(REQ_FREE_RANGE, 32'h0000_1000, 32'h0002_1FFF, 0, 32'h0000_0000, ST_OK);
    add_row(REQ_ALLOC,      32'h0000_0000, 32'h0000_0000, 0, 32'h0000_0000, ST_OK);
    add_row(REQ_FREE_PAGE,  32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_FREE_RANGE, 32'hFFFF_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_BAD_ADDR);
    add_row(REQ_FREE_RANGE, 32'h0000_0000, 32'h1000_0000, 1, 32'h0000_0000, ST_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].start_a, directed_rows[i].end_a,
                   directed_rows[i].known, directed_rows[i].want);
    end

    // Random phases, each under its own page_count: one page, none, small
    // pools that run dry, the exact capacity, and values above it up to the
    // largest the register holds. The last phase takes a random count.
    foreach (phase_counts[ph]) begin
      if (ph == 7) phase_counts[ph] = 17'($urandom_range(2, 2000));
      write_page_count(phase_counts[ph]);
      span = (phase_counts[ph] < 360) ? phase_counts[ph] + 40 : 400;
      repeat (PHASE_ITEMS) send_random_request(span);
    end

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d allocations, %0d page frees, %0d range reserves, %0d range frees",
             requests_by_type[REQ_ALLOC], requests_by_type[REQ_FREE_PAGE],
             requests_by_type[REQ_RESERVE], requests_by_type[REQ_FREE_RANGE]);
    $display("under %0d page_count values: %0d ok, %0d out of pages, %0d rejected; %0d mismatches",
             settings_done, results_by_status[ST_OK], results_by_status[ST_NO_PAGE],
             results_by_status[ST_BAD_ADDR], mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_word_unit.sv
rtl/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_test.sv
